@@ design/mexp_pkg.sv @@
package mexp_pkg;

  // apb register map: one register per 32-bit word
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic        REG_MODULUS = 1'b0;  // word select paddr[2]

  // base field is fixed at 32 bits
  localparam int unsigned BASE_W = 32;

endpackage

@@ design/modular_exponentiation.sv @@
// the work grows with the number of significant exponent bits; a zero exponent or zero
// modulus skips the base reduction and the multiplies
// throughput: one item at a time; a single shift-and-subtract modular unit does the
// base reduction and every multiply one multiplier bit per cycle
// reset: rst synchronous active high, modulus returns to 1, sequencer idle, no result held
module modular_exponentiation #(
  parameter int unsigned EXP_BITS = 32,
  parameter int unsigned MOD_BITS = 31
) (
  input  logic clk,
  input  logic rst,
  // input stream
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // fields from bit 0: base_value[31:0], exponent[EXP_BITS-1:0]
  input  logic [((32+EXP_BITS+7)/8)*8-1:0]       s_tdata,
  // result stream
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // fields from bit 0: power_result[MOD_BITS-1:0]
  output logic [((MOD_BITS+7)/8)*8-1:0]          m_tdata,
  // configuration port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [mexp_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [mexp_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [mexp_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                   pready
);
  import mexp_pkg::*;

  localparam int unsigned OUT_W = ((MOD_BITS+7)/8)*8;
  localparam int unsigned T_W   = MOD_BITS + 2;   // 2r + addend stays below 3m
  localparam int unsigned OPA_W = BASE_W;         // MOD_BITS never exceeds 32
  localparam int unsigned CNT_W = 5;

  typedef enum logic [2:0] {
    S_IDLE, S_RED, S_BIT, S_MUL, S_SQR, S_OUT
  } state_t;

  state_t               state;
  logic [MOD_BITS-1:0]  modulus;
  logic [MOD_BITS-1:0]  accumulator;
  logic [MOD_BITS-1:0]  running_square;
  logic [EXP_BITS-1:0]  exponent_left;
  logic [MOD_BITS-1:0]  rem;       // partial remainder of the shared unit
  logic [OPA_W-1:0]     opa;       // base or multiplier bits, consumed from the msb
  logic [CNT_W-1:0]     cnt;
  logic [MOD_BITS-1:0]  result;

  logic [BASE_W-1:0]    in_base;
  logic [EXP_BITS-1:0]  in_exp;
  logic                 in_take;
  logic                 cfg_wr;

  // shared modular step
  logic [T_W-1:0]       addend;
  logic [T_W-1:0]       t_sum;
  logic [T_W:0]         t_m1;
  logic [T_W:0]         t_m2;
  logic [MOD_BITS-1:0]  step_out;

  assign in_base = s_tdata[BASE_W-1:0];
  assign in_exp  = s_tdata[BASE_W+EXP_BITS-1:BASE_W];
  assign s_tready = (state == S_IDLE);
  assign in_take  = s_tvalid && s_tready;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MODULUS);
  assign prdata = (paddr[2] == REG_MODULUS) ?
                  APB_DATA_W'(modulus) : '0;

  assign m_tdata = OUT_W'(result);

  // reduction adds one base bit; a multiply adds the multiplicand when the bit is set
  always_comb begin
    if (state == S_RED) begin
      addend = T_W'(opa[OPA_W-1]);
    end else begin
      addend = opa[OPA_W-1] ? T_W'(running_square) : '0;
    end
    t_sum = T_W'({rem, 1'b0}) + addend;
    t_m1  = {1'b0, t_sum} - (T_W+1)'(modulus);
    t_m2  = {1'b0, t_sum} - (T_W+1)'({modulus, 1'b0});
    // t_sum < 3m: pick t, t-m or t-2m
    if (!t_m2[T_W]) begin
      step_out = t_m2[MOD_BITS-1:0];
    end else if (!t_m1[T_W]) begin
      step_out = t_m1[MOD_BITS-1:0];
    end else begin
      step_out = t_sum[MOD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      modulus        <= MOD_BITS'(1);
      m_tvalid       <= 1'b0;
      accumulator    <= '0;
      running_square <= '0;
      exponent_left  <= '0;
      rem            <= '0;
      opa            <= '0;
      cnt            <= '0;
      result         <= '0;
    end else begin
      if (cfg_wr) begin
        modulus <= pwdata[MOD_BITS-1:0];
      end
      // a new result goes out once the previous one has left
      if (state == S_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            exponent_left <= in_exp;
            rem           <= '0;
            opa           <= in_base;
            cnt           <= CNT_W'(BASE_W - 1);
            // zero exponent gives 1 unreduced, zero modulus gives 0
            if (in_exp == '0) begin
              accumulator <= MOD_BITS'(1);
              state       <= S_OUT;
            end else if (modulus == '0) begin
              accumulator <= '0;
              state       <= S_OUT;
            end else begin
              accumulator <= MOD_BITS'(1);
              state       <= S_RED;
            end
          end
        end
        S_RED: begin
          rem <= step_out;
          opa <= opa << 1;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            running_square <= step_out;
            state          <= S_BIT;
          end
        end
        S_BIT: begin
          rem <= '0;
          cnt <= CNT_W'(MOD_BITS - 1);
          if (exponent_left == '0) begin
            state <= S_OUT;
          end else if (exponent_left[0]) begin
            opa   <= OPA_W'(accumulator) << (OPA_W - MOD_BITS);
            state <= S_MUL;
          end else begin
            opa   <= OPA_W'(running_square) << (OPA_W - MOD_BITS);
            state <= S_SQR;
          end
        end
        S_MUL: begin
          if (cnt == '0) begin
            accumulator <= step_out;
            rem         <= '0;
            opa         <= OPA_W'(running_square) << (OPA_W - MOD_BITS);
            cnt         <= CNT_W'(MOD_BITS - 1);
            state       <= S_SQR;
          end else begin
            rem <= step_out;
            opa <= opa << 1;
            cnt <= cnt - 1'b1;
          end
        end
        S_SQR: begin
          rem <= step_out;
          opa <= opa << 1;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            running_square <= step_out;
            exponent_left  <= exponent_left >> 1;
            state          <= S_BIT;
          end
        end
        S_OUT: begin
          // hold until the previous result has left
          if (!m_tvalid || m_tready) begin
            result <= accumulator;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
